// ----- design/fmwd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Filtered min/max waveform decimator package
// Ring geometry, datapath widths and configuration register indexes.
// ----------------------------------------------------------------------------
package fmwd_pkg;

   localparam int RING_COLUMNS = 128;
   localparam int RING_IDX_W   = $clog2(RING_COLUMNS);

   localparam int SAMPLE_W = 16;
   localparam int OFFSET_W = 7;
   localparam int COEF_W   = 24;
   localparam int GAIN_W   = 15;
   localparam int DEC_W    = 16;
   localparam int COLS_W   = 8;
   localparam int Y_W      = 32;
   localparam int PROD_W   = COEF_W + Y_W;
   localparam int ACC_W    = PROD_W + 4;

   localparam int Y_SHIFT     = 20;
   localparam int SCALE_SHIFT = 15;

   localparam int SUM_W = ((RING_IDX_W > OFFSET_W) ? RING_IDX_W : OFFSET_W) + 2;
   localparam int DIV_W = $clog2(SUM_W);
   localparam int TAPS  = 5;
   localparam int STEP_W = $clog2(TAPS + 1);

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = COEF_W;

   localparam logic [CSR_ADDR_W-1:0] CSR_DECIMATION   = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_GAIN         = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_COLUMNS_USED = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_COEF_B0      = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] CSR_COEF_B1      = 3'd4;
   localparam logic [CSR_ADDR_W-1:0] CSR_COEF_B2      = 3'd5;
   localparam logic [CSR_ADDR_W-1:0] CSR_COEF_A1      = 3'd6;
   localparam logic [CSR_ADDR_W-1:0] CSR_COEF_A2      = 3'd7;

   localparam logic       CMD_PUSH = 1'b0;
   localparam logic       CMD_READ = 1'b1;

endpackage

// ----- design/filtered_minmax_waveform_decimator_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Filtered min/max waveform decimator
// Biquad filter on each pushed sample, gain with rounding and saturation,
// and a ring of min/max display columns that a read transfer returns.
//
//   Channel  Direction  Payload
//   req      in         tuser: command; tdata: sample [15:0], column_offset [22:16]
//   rsp      out        tdata: column_min [15:0], column_max [31:16]
//   csr      in         csr_windex selects the register, csr_wdata holds the value
//
// A push finishes before req_tready rises again: the one shared 24x32
// multiplier for the five taps, then rounding, the gain product, scaling and
// the ring update. A read runs nine steps of the shared compare-and-subtract
// for the ring position, then the registered memory read. After reset a
// clearing pass zeroes every ring column before the first transfer is taken.
// A read result waits in the output register while later pushes proceed; a
// second read holds until that result is taken.
// ----------------------------------------------------------------------------
module filtered_minmax_waveform_decimator_top
   import fmwd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [23:0]           req_tdata,  // sample [15:0], column_offset [22:16]
   input  logic                  req_tuser,  // command [0]
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [31:0]           rsp_tdata,  // column_min [15:0], column_max [31:16]
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_windex,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_MUL,
      ST_ROUND,
      ST_GMUL,
      ST_SCALE,
      ST_UPDATE,
      ST_MOD,
      ST_RD_ADDR,
      ST_RD_DATA
   } state_type;

   state_type state_ff, state_in;

   logic [DEC_W-1:0]         dec_ff, dec_in;
   logic [GAIN_W-1:0]        gain_ff, gain_in;
   logic [COLS_W-1:0]        cols_ff, cols_in;
   logic signed [COEF_W-1:0] b0_ff, b0_in, b1_ff, b1_in, b2_ff, b2_in;
   logic signed [COEF_W-1:0] a1_ff, a1_in, a2_ff, a2_in;

   logic [RING_IDX_W-1:0]      clr_ff, clr_in;
   logic [RING_IDX_W-1:0]      wi_ff, wi_in;
   logic [DEC_W-1:0]           phase_ff, phase_in;
   logic signed [SAMPLE_W-1:0] x_ff, x_in, x1_ff, x1_in, x2_ff, x2_in;
   logic signed [Y_W-1:0]      y1_ff, y1_in, y2_ff, y2_in;
   logic [STEP_W-1:0]          step_ff, step_in;
   logic signed [PROD_W-1:0]   prod_ff, prod_in;
   logic signed [ACC_W-1:0]    acc_ff, acc_in;
   logic signed [SAMPLE_W-1:0] s_ff, s_in;
   logic [SUM_W-1:0]           rem_ff, rem_in;
   logic [DIV_W-1:0]           div_ff, div_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [31:0]                rsp_data_ff, rsp_data_in;

   logic [31:0]           ring [RING_COLUMNS];
   logic [31:0]           rd_ff;
   logic                  mem_we;
   logic [RING_IDX_W-1:0] mem_waddr, mem_raddr;
   logic [31:0]           mem_wdata;

   logic signed [COEF_W-1:0] mul_a;
   logic signed [Y_W-1:0]    mul_b;
   logic signed [PROD_W-1:0] mul_p;

   logic signed [ACC_W-1:0]  acc_rnd, acc_sh;
   logic [ACC_W-Y_W:0]       acc_hi;
   logic signed [Y_W-1:0]    y_sat;
   logic signed [PROD_W-1:0] p_rnd, p_sh;
   logic [PROD_W-SAMPLE_W:0] p_hi;
   logic signed [SAMPLE_W-1:0] s_sat;

   logic [COLS_W-1:0]      n_act;
   logic [DEC_W-1:0]       dec_eff;
   logic [DEC_W:0]         phase_inc;
   logic [SUM_W-1:0]       wi_inc;
   logic [RING_IDX_W-1:0]  wi_new;
   logic [2*SUM_W-1:0]     div_trial, rem_ext;
   logic signed [SAMPLE_W-1:0] col_min, col_max;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign mul_p = mul_a * mul_b;

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      if (state_ff == ST_GMUL) begin
         mul_a = signed'(COEF_W'(gain_ff));
         mul_b = y1_ff;
      end else begin
         unique case (step_ff)
            3'd0: begin
               mul_a = b0_ff;
               mul_b = Y_W'(x_ff);
            end
            3'd1: begin
               mul_a = b1_ff;
               mul_b = Y_W'(x1_ff);
            end
            3'd2: begin
               mul_a = b2_ff;
               mul_b = Y_W'(x2_ff);
            end
            3'd3: begin
               mul_a = a1_ff;
               mul_b = y1_ff;
            end
            3'd4: begin
               mul_a = a2_ff;
               mul_b = y2_ff;
            end
            default: begin
               mul_a = '0;
               mul_b = '0;
            end
         endcase
      end
   end

   always_comb begin
      acc_rnd = acc_ff + (acc_ff[ACC_W-1] ? ACC_W'((1 << (Y_SHIFT - 1)) - 1)
                                          : ACC_W'(1 << (Y_SHIFT - 1)));
      acc_sh  = acc_rnd >>> Y_SHIFT;
      acc_hi  = acc_sh[ACC_W-1:Y_W-1];
      if ((&acc_hi) || !(|acc_hi)) begin
         y_sat = acc_sh[Y_W-1:0];
      end else if (acc_hi[ACC_W-Y_W]) begin
         y_sat = {1'b1, {(Y_W-1){1'b0}}};
      end else begin
         y_sat = {1'b0, {(Y_W-1){1'b1}}};
      end

      p_rnd = prod_ff + (prod_ff[PROD_W-1] ? PROD_W'((1 << (SCALE_SHIFT - 1)) - 1)
                                           : PROD_W'(1 << (SCALE_SHIFT - 1)));
      p_sh  = p_rnd >>> SCALE_SHIFT;
      p_hi  = p_sh[PROD_W-1:SAMPLE_W-1];
      if ((&p_hi) || !(|p_hi)) begin
         s_sat = p_sh[SAMPLE_W-1:0];
      end else if (p_hi[PROD_W-SAMPLE_W]) begin
         s_sat = {1'b1, {(SAMPLE_W-1){1'b0}}};
      end else begin
         s_sat = {1'b0, {(SAMPLE_W-1){1'b1}}};
      end
   end

   always_comb begin
      if (cols_ff == '0) begin
         n_act = COLS_W'(1);
      end else if (32'(cols_ff) > RING_COLUMNS) begin
         n_act = COLS_W'(RING_COLUMNS);
      end else begin
         n_act = cols_ff;
      end
      dec_eff   = (dec_ff == '0) ? DEC_W'(1) : dec_ff;
      phase_inc = {1'b0, phase_ff} + (DEC_W+1)'(1);
      wi_inc    = SUM_W'(wi_ff) + SUM_W'(1);
      wi_new    = (wi_inc >= SUM_W'(n_act)) ? '0 : RING_IDX_W'(wi_inc);
      div_trial = (2*SUM_W)'(n_act) << div_ff;
      rem_ext   = (2*SUM_W)'(rem_ff);
      col_min   = signed'(rd_ff[15:0]);
      col_max   = signed'(rd_ff[31:16]);
      if (s_ff < col_min) begin
         col_min = s_ff;
      end
      if (s_ff > col_max) begin
         col_max = s_ff;
      end
   end

   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = wi_ff;
      mem_wdata = '0;
      mem_raddr = wi_ff;
      if (state_ff == ST_CLEAR) begin
         mem_we    = 1'b1;
         mem_waddr = clr_ff;
      end
      if (state_ff == ST_UPDATE) begin
         mem_we = 1'b1;
         if (phase_ff == '0) begin
            mem_waddr = wi_new;
            mem_wdata = {s_ff, s_ff};
         end else begin
            mem_wdata = {col_max, col_min};
         end
      end
      if (state_ff == ST_RD_ADDR || state_ff == ST_RD_DATA) begin
         mem_raddr = RING_IDX_W'(rem_ff);
      end
   end

   always_comb begin
      state_in     = state_ff;
      dec_in       = dec_ff;
      gain_in      = gain_ff;
      cols_in      = cols_ff;
      b0_in        = b0_ff;
      b1_in        = b1_ff;
      b2_in        = b2_ff;
      a1_in        = a1_ff;
      a2_in        = a2_ff;
      clr_in       = clr_ff;
      wi_in        = wi_ff;
      phase_in     = phase_ff;
      x_in         = x_ff;
      x1_in        = x1_ff;
      x2_in        = x2_ff;
      y1_in        = y1_ff;
      y2_in        = y2_ff;
      step_in      = step_ff;
      prod_in      = prod_ff;
      acc_in       = acc_ff;
      s_in         = s_ff;
      rem_in       = rem_ff;
      div_in       = div_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;

      if (csr_we) begin
         unique case (csr_windex)
            CSR_DECIMATION:   dec_in  = csr_wdata[DEC_W-1:0];
            CSR_GAIN:         gain_in = csr_wdata[GAIN_W-1:0];
            CSR_COLUMNS_USED: cols_in = csr_wdata[COLS_W-1:0];
            CSR_COEF_B0:      b0_in   = signed'(csr_wdata);
            CSR_COEF_B1:      b1_in   = signed'(csr_wdata);
            CSR_COEF_B2:      b2_in   = signed'(csr_wdata);
            CSR_COEF_A1:      a1_in   = signed'(csr_wdata);
            CSR_COEF_A2:      a2_in   = signed'(csr_wdata);
         endcase
      end

      unique case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + RING_IDX_W'(1);
            if (clr_ff == RING_IDX_W'(RING_COLUMNS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_tvalid) begin
               if (req_tuser == CMD_PUSH) begin
                  x_in     = signed'(req_tdata[SAMPLE_W-1:0]);
                  acc_in   = '0;
                  step_in  = '0;
                  state_in = ST_MUL;
               end else begin
                  rem_in   = SUM_W'(wi_ff) + SUM_W'(1)
                           + SUM_W'(req_tdata[SAMPLE_W +: OFFSET_W]);
                  div_in   = DIV_W'(SUM_W - 1);
                  state_in = ST_MOD;
               end
            end
         end
         ST_MUL: begin
            if (step_ff != '0) begin
               acc_in = acc_ff + ACC_W'(prod_ff);
            end
            prod_in = mul_p;
            step_in = step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(TAPS)) begin
               state_in = ST_ROUND;
            end
         end
         ST_ROUND: begin
            x1_in    = x_ff;
            x2_in    = x1_ff;
            y1_in    = y_sat;
            y2_in    = y1_ff;
            state_in = ST_GMUL;
         end
         ST_GMUL: begin
            prod_in  = mul_p;
            state_in = ST_SCALE;
         end
         ST_SCALE: begin
            s_in     = s_sat;
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            if (phase_ff == '0) begin
               wi_in = wi_new;
            end
            phase_in = (phase_inc >= {1'b0, dec_eff}) ? '0 : phase_inc[DEC_W-1:0];
            state_in = ST_IDLE;
         end
         ST_MOD: begin
            if (rem_ext >= div_trial) begin
               rem_in = SUM_W'(rem_ext - div_trial);
            end
            div_in = div_ff - DIV_W'(1);
            if (div_ff == '0) begin
               state_in = ST_RD_ADDR;
            end
         end
         ST_RD_ADDR: begin
            state_in = ST_RD_DATA;
         end
         ST_RD_DATA: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = rd_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         dec_ff       <= DEC_W'(1);
         gain_ff      <= GAIN_W'(64);
         cols_ff      <= COLS_W'(128);
         b0_ff        <= COEF_W'(1 << Y_SHIFT);
         b1_ff        <= '0;
         b2_ff        <= '0;
         a1_ff        <= '0;
         a2_ff        <= '0;
         clr_ff       <= '0;
         wi_ff        <= '0;
         phase_ff     <= '0;
         x1_ff        <= '0;
         x2_ff        <= '0;
         y1_ff        <= '0;
         y2_ff        <= '0;
         step_ff      <= '0;
         div_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         dec_ff       <= dec_in;
         gain_ff      <= gain_in;
         cols_ff      <= cols_in;
         b0_ff        <= b0_in;
         b1_ff        <= b1_in;
         b2_ff        <= b2_in;
         a1_ff        <= a1_in;
         a2_ff        <= a2_in;
         clr_ff       <= clr_in;
         wi_ff        <= wi_in;
         phase_ff     <= phase_in;
         x1_ff        <= x1_in;
         x2_ff        <= x2_in;
         y1_ff        <= y1_in;
         y2_ff        <= y2_in;
         step_ff      <= step_in;
         div_ff       <= div_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      x_ff        <= x_in;
      prod_ff     <= prod_in;
      acc_ff      <= acc_in;
      s_ff        <= s_in;
      rem_ff      <= rem_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         ring[mem_waddr] <= mem_wdata;
      end
      rd_ff <= ring[mem_raddr];
   end

endmodule
